// ===== rtl/mm_pkg.sv =====
// Package for the matrix multiply block: types, codes and a helper function.
package mm_pkg;

    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = $clog2(MAX_DIM);
    localparam int ADDR_W    = 2 * IDX_W;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int DIM_W     = 4;
    localparam int VAL_W     = 32;
    localparam int PROD_W    = 2 * VAL_W;
    localparam int ACC_W     = PROD_W + IDX_W;
    localparam int FRAC_W    = 16;
    localparam int SHIFT_W   = ACC_W - FRAC_W;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] ACTION_LOAD_A = 2'd0;
    localparam logic [1:0] ACTION_LOAD_B = 2'd1;
    localparam logic [1:0] ACTION_START  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_A_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_ROWS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
    localparam logic [DIM_W-1:0] DIM_MAX   = DIM_W'(MAX_DIM);

    typedef struct packed {
        logic [1:0]              action;
        logic [2:0]              row;
        logic [2:0]              col;
        logic signed [VAL_W-1:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic [2:0]              out_row;
        logic [2:0]              out_col;
        logic signed [VAL_W-1:0] product_value;
        logic                    saturated;
        logic                    last;
    } result_word_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             step;
        logic [IDX_W-1:0] i;
        logic [IDX_W-1:0] j;
        logic [IDX_W-1:0] k;
        logic             first;
        logic             last_k;
        logic             zero;
        logic             final_elem;
    } ctrl_cmd_t;

    typedef struct packed {
        logic final_out;
    } dp_status_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_MAX) ? DIM_MAX : d;
    endfunction

endpackage

// ===== rtl/mm_ctrl.sv =====
// Controller for the matrix multiply block: configuration, sequencing and busy.
module mm_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  mm_pkg::cmd_word_t          command,
    input  logic                       cfg_valid,
    input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]   cfg_data,
    input  mm_pkg::dp_status_t         status,
    output logic                       busy,
    output mm_pkg::ctrl_cmd_t          cmd
);

    mm_pkg::state_t state_reg, state_next;

    logic [mm_pkg::DIM_W-1:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [mm_pkg::IDX_W-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;

    logic [mm_pkg::DIM_W-1:0] rows, cols, ac, br, inner, inner_eff;
    logic                     zero_inner, last_i, last_j, last_k;
    logic                     accept, go;

    assign rows       = mm_pkg::clamp_dim(a_rows_reg);
    assign cols       = mm_pkg::clamp_dim(b_cols_reg);
    assign ac         = mm_pkg::clamp_dim(a_cols_reg);
    assign br         = mm_pkg::clamp_dim(b_rows_reg);
    assign inner      = (ac < br) ? ac : br;
    assign zero_inner = (inner == '0);
    assign inner_eff  = zero_inner ? mm_pkg::DIM_W'(1) : inner;

    assign last_k = ({1'b0, k_reg} == (inner_eff - mm_pkg::DIM_W'(1)));
    assign last_i = ({1'b0, i_reg} == (rows - mm_pkg::DIM_W'(1)));
    assign last_j = ({1'b0, j_reg} == (cols - mm_pkg::DIM_W'(1)));

    assign accept = start && !busy;
    assign go     = accept && (command.action == mm_pkg::ACTION_START)
                    && (rows != '0) && (cols != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= mm_pkg::ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            a_rows_reg <= mm_pkg::DIM_RESET;
            a_cols_reg <= mm_pkg::DIM_RESET;
            b_rows_reg <= mm_pkg::DIM_RESET;
            b_cols_reg <= mm_pkg::DIM_RESET;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    mm_pkg::REG_A_ROWS: a_rows_reg <= cfg_data;
                    mm_pkg::REG_A_COLS: a_cols_reg <= cfg_data;
                    mm_pkg::REG_B_ROWS: b_rows_reg <= cfg_data;
                    mm_pkg::REG_B_COLS: b_cols_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                if (go)
                    state_next = mm_pkg::ST_RUN;
            end
            mm_pkg::ST_RUN:
            begin
                if (last_k && last_i && last_j)
                    state_next = mm_pkg::ST_DRAIN;
            end
            mm_pkg::ST_DRAIN:
            begin
                if (status.final_out)
                    state_next = mm_pkg::ST_IDLE;
            end
            default:
                state_next = mm_pkg::ST_IDLE;
        endcase
    end

    // advance inner, row, then column counters
    always_comb
    begin
        i_next = i_reg;
        j_next = j_reg;
        k_next = k_reg;
        if (go)
        begin
            i_next = '0;
            j_next = '0;
            k_next = '0;
        end
        else if (state_reg == mm_pkg::ST_RUN)
        begin
            if (!last_k)
                k_next = k_reg + mm_pkg::IDX_W'(1);
            else
            begin
                k_next = '0;
                if (!last_i)
                    i_next = i_reg + mm_pkg::IDX_W'(1);
                else
                begin
                    i_next = '0;
                    j_next = last_j ? '0 : j_reg + mm_pkg::IDX_W'(1);
                end
            end
        end
    end

    // outputs
    always_comb
    begin
        busy           = (state_reg != mm_pkg::ST_IDLE);
        cmd.wr_a       = 1'b0;
        cmd.wr_b       = 1'b0;
        cmd.step       = 1'b0;
        cmd.i          = i_reg;
        cmd.j          = j_reg;
        cmd.k          = k_reg;
        cmd.first      = (k_reg == '0);
        cmd.last_k     = last_k;
        cmd.zero       = zero_inner;
        cmd.final_elem = last_i && last_j;
        case (state_reg)
            mm_pkg::ST_IDLE:
            begin
                cmd.wr_a = accept && (command.action == mm_pkg::ACTION_LOAD_A);
                cmd.wr_b = accept && (command.action == mm_pkg::ACTION_LOAD_B);
            end
            mm_pkg::ST_RUN:
                cmd.step = 1'b1;
            mm_pkg::ST_DRAIN:
                cmd.step = 1'b0;
            default:
                cmd.step = 1'b0;
        endcase
    end

endmodule

// ===== rtl/mm_datapath.sv =====
// Datapath for the matrix multiply block: element stores, multiplier, accumulator, output.
module mm_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mm_pkg::cmd_word_t   command,
    input  mm_pkg::ctrl_cmd_t   cmd,
    output mm_pkg::dp_status_t  status,
    output logic                strobe,
    output mm_pkg::result_word_t result
);

    logic [mm_pkg::VAL_W-1:0] mem_a [mm_pkg::DEPTH];
    logic [mm_pkg::VAL_W-1:0] mem_b [mm_pkg::DEPTH];
    logic [mm_pkg::DEPTH-1:0] vld_a_reg, vld_b_reg;

    logic [mm_pkg::ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    // stage 1: registered store reads
    logic [mm_pkg::VAL_W-1:0] a_q_reg, b_q_reg;
    logic                     a_v_reg, b_v_reg;
    logic                     s1_step_reg, s1_first_reg, s1_last_reg, s1_zero_reg, s1_fin_reg;
    logic [mm_pkg::IDX_W-1:0] s1_i_reg, s1_j_reg;

    // stage 2: product
    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic                     s2_step_reg, s2_first_reg, s2_last_reg, s2_fin_reg;
    logic [mm_pkg::IDX_W-1:0] s2_i_reg, s2_j_reg;

    // stage 3: accumulate
    logic signed [mm_pkg::ACC_W-1:0] acc_reg;
    logic                     s3_done_reg, s3_fin_reg;
    logic [mm_pkg::IDX_W-1:0] s3_i_reg, s3_j_reg;

    // stage 4: result word
    logic                 strobe_reg;
    mm_pkg::result_word_t result_reg;

    logic signed [mm_pkg::VAL_W-1:0]   a_op, b_op;
    logic signed [mm_pkg::ACC_W-1:0]   prod_ext;
    logic signed [mm_pkg::SHIFT_W-1:0] shifted;
    logic                              fits;

    assign wr_addr   = {command.row, command.col};
    assign rd_addr_a = {cmd.i, cmd.k};
    assign rd_addr_b = {cmd.k, cmd.j};

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            mem_a[wr_addr] <= command.value;
        if (cmd.wr_b)
            mem_b[wr_addr] <= command.value;
        a_q_reg <= mem_a[rd_addr_a];
        b_q_reg <= mem_b[rd_addr_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg   <= '0;
            vld_b_reg   <= '0;
            a_v_reg     <= 1'b0;
            b_v_reg     <= 1'b0;
            s1_step_reg <= 1'b0;
            s2_step_reg <= 1'b0;
            s3_done_reg <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.wr_a)
                vld_a_reg[wr_addr] <= 1'b1;
            if (cmd.wr_b)
                vld_b_reg[wr_addr] <= 1'b1;
            a_v_reg     <= vld_a_reg[rd_addr_a];
            b_v_reg     <= vld_b_reg[rd_addr_b];
            s1_step_reg <= cmd.step;
            s2_step_reg <= s1_step_reg;
            s3_done_reg <= s2_step_reg && s2_last_reg;
            strobe_reg  <= s3_done_reg;
        end
    end

    assign a_op = (a_v_reg && !s1_zero_reg) ? $signed(a_q_reg) : '0;
    assign b_op = (b_v_reg && !s1_zero_reg) ? $signed(b_q_reg) : '0;

    assign prod_ext = {{mm_pkg::IDX_W{prod_reg[mm_pkg::PROD_W-1]}}, prod_reg};

    assign shifted = acc_reg[mm_pkg::ACC_W-1:mm_pkg::FRAC_W];
    assign fits    = (&shifted[mm_pkg::SHIFT_W-1:mm_pkg::VAL_W-1])
                     || (~|shifted[mm_pkg::SHIFT_W-1:mm_pkg::VAL_W-1]);

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s1_last_reg  <= cmd.last_k;
        s1_zero_reg  <= cmd.zero;
        s1_fin_reg   <= cmd.final_elem;
        s1_i_reg     <= cmd.i;
        s1_j_reg     <= cmd.j;

        prod_reg     <= a_op * b_op;
        s2_first_reg <= s1_first_reg;
        s2_last_reg  <= s1_last_reg;
        s2_fin_reg   <= s1_fin_reg;
        s2_i_reg     <= s1_i_reg;
        s2_j_reg     <= s1_j_reg;

        if (s2_step_reg)
            acc_reg <= s2_first_reg ? prod_ext : acc_reg + prod_ext;
        s3_fin_reg <= s2_fin_reg;
        s3_i_reg   <= s2_i_reg;
        s3_j_reg   <= s2_j_reg;

        result_reg.out_row   <= s3_i_reg;
        result_reg.out_col   <= s3_j_reg;
        result_reg.saturated <= !fits;
        result_reg.last      <= s3_fin_reg;
        if (fits)
            result_reg.product_value <= shifted[mm_pkg::VAL_W-1:0];
        else if (shifted[mm_pkg::SHIFT_W-1])
            result_reg.product_value <= {1'b1, {(mm_pkg::VAL_W-1){1'b0}}};
        else
            result_reg.product_value <= {1'b0, {(mm_pkg::VAL_W-1){1'b1}}};
    end

    assign strobe           = strobe_reg;
    assign result           = result_reg;
    assign status.final_out = strobe_reg && result_reg.last;

endmodule

// ===== rtl/matrix_multiply.sv =====
// Top level of the matrix multiply block: controller and datapath.
//
// channel   direction  handshake                    word
// command   in         start && !busy               mm_pkg::cmd_word_t
// config    in         cfg_valid && cfg_ready       cfg_index, cfg_data
// result    out        strobe, once per word        mm_pkg::result_word_t
//
// Loads are taken back to back.
// A start walks C in column order, one inner step per cycle through the single multiplier.
// busy stays high from a start with nonzero rows and cols until the cycle after the last word.
// Reset clears the element stores through per-entry valid bits and sets all
// dimensions to 8; result words cannot be held off by the receiver.
module matrix_multiply (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  mm_pkg::cmd_word_t            command,
    output logic                         busy,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mm_pkg::DIM_W-1:0]     cfg_data,
    output logic                         strobe,
    output mm_pkg::result_word_t         result
);

    mm_pkg::ctrl_cmd_t  cmd;
    mm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    mm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    mm_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .command (command),
        .cmd     (cmd),
        .status  (status),
        .strobe  (strobe),
        .result  (result)
    );

endmodule

// ===== tb/tb_top.sv =====
// Testbench for matrix_multiply: directed and random element loads and multiplies.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [1:0] ACTION_UNUSED = 2'd3;
    localparam int RANDOM_WORDS = 125;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;
    localparam int WANT_DEPTH = 128;
    localparam logic signed [71:0] Q_MAX = 72'sd2147483647;
    localparam logic signed [71:0] Q_MIN = -72'sd2147483648;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    mm_pkg::cmd_word_t command = '0;
    logic busy;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [mm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [mm_pkg::DIM_W-1:0] cfg_data = '0;
    logic strobe;
    mm_pkg::result_word_t result;

    logic signed [mm_pkg::VAL_W-1:0] a_store [mm_pkg::MAX_DIM][mm_pkg::MAX_DIM];
    logic signed [mm_pkg::VAL_W-1:0] b_store [mm_pkg::MAX_DIM][mm_pkg::MAX_DIM];
    logic [mm_pkg::DIM_W-1:0] dim_reg [4];
    mm_pkg::result_word_t want_buf [WANT_DEPTH];
    int want_wr = 0;
    int want_rd = 0;

    bit gaps_on = 1'b1;
    int error_count = 0;
    int cycle_count = 0;
    int load_count = 0;
    int multiply_count = 0;
    int ignored_count = 0;
    int checked_count = 0;
    int saturated_count = 0;

    matrix_multiply i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .command   (command),
        .busy      (busy),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .strobe    (strobe),
        .result    (result)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int unsigned limit_dim(input logic [mm_pkg::DIM_W-1:0] d);
        return (int'(d) > mm_pkg::MAX_DIM) ? mm_pkg::MAX_DIM : int'(d);
    endfunction

    function automatic void compute_c();
        int unsigned rows;
        int unsigned cols;
        int unsigned inner;
        int unsigned total;
        int unsigned n;
        logic signed [71:0] acc;
        logic signed [71:0] scaled;
        longint prod;
        mm_pkg::result_word_t w;
        rows  = limit_dim(dim_reg[mm_pkg::REG_A_ROWS]);
        cols  = limit_dim(dim_reg[mm_pkg::REG_B_COLS]);
        inner = limit_dim(dim_reg[mm_pkg::REG_A_COLS]);
        if (limit_dim(dim_reg[mm_pkg::REG_B_ROWS]) < inner)
            inner = limit_dim(dim_reg[mm_pkg::REG_B_ROWS]);
        total = rows * cols;
        n = 0;
        for (int unsigned j = 0; j < cols; j++)
        begin
            for (int unsigned i = 0; i < rows; i++)
            begin
                acc = '0;
                for (int unsigned k = 0; k < inner; k++)
                begin
                    prod = longint'(a_store[i][k]) * longint'(b_store[k][j]);
                    acc = acc + prod;
                end
                scaled = acc >>> mm_pkg::FRAC_W;
                w.out_row = i[2:0];
                w.out_col = j[2:0];
                if (scaled > Q_MAX)
                begin
                    w.product_value = 32'sh7FFF_FFFF;
                    w.saturated = 1'b1;
                end
                else if (scaled < Q_MIN)
                begin
                    w.product_value = 32'sh8000_0000;
                    w.saturated = 1'b1;
                end
                else
                begin
                    w.product_value = scaled[31:0];
                    w.saturated = 1'b0;
                end
                n++;
                w.last = (n == total);
                want_buf[7'(want_wr)] = w;
                want_wr++;
            end
        end
    endfunction

    function automatic void apply_command(input mm_pkg::cmd_word_t w);
        case (w.action)
            mm_pkg::ACTION_LOAD_A:
            begin
                a_store[w.row][w.col] = w.value;
                load_count++;
            end
            mm_pkg::ACTION_LOAD_B:
            begin
                b_store[w.row][w.col] = w.value;
                load_count++;
            end
            mm_pkg::ACTION_START:
            begin
                compute_c();
                multiply_count++;
            end
            default: ignored_count++;
        endcase
    endfunction

    function automatic mm_pkg::cmd_word_t make_word(input logic [1:0] act, input logic [2:0] r,
                                                    input logic [2:0] c, input logic [31:0] v);
        mm_pkg::cmd_word_t w;
        w.action = act;
        w.row = r;
        w.col = c;
        w.value = v;
        return w;
    endfunction

    function automatic mm_pkg::cmd_word_t start_word();
        return make_word(mm_pkg::ACTION_START, 3'($urandom_range(7)), 3'($urandom_range(7)),
                         $urandom);
    endfunction

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(9)) inside
            [0:3]: v = $urandom_range(32'h7FFFF);
            [4:6]: v = $urandom;
            7:
            begin
                case ($urandom_range(3))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    2: v = 32'h0000_0000;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: v = $urandom >> $urandom_range(8, 24);
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    function automatic logic [mm_pkg::DIM_W-1:0] pick_dim();
        int unsigned r;
        r = $urandom_range(19);
        if (r < 12)
            return 4'($urandom_range(1, 4));
        if (r < 17)
            return 4'($urandom_range(5, 8));
        return $urandom_range(1) ? 4'd0 : 4'($urandom_range(9, 15));
    endfunction

    function automatic logic [2:0] pick_index(input logic [mm_pkg::DIM_W-1:0] d);
        int unsigned lim;
        lim = limit_dim(d);
        if (lim == 0 || $urandom_range(4) == 0)
            return 3'($urandom_range(7));
        return 3'($urandom_range(lim - 1));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < PRINT_LIMIT)
            $display("MISMATCH %s: got %h, want %h (cycle %0d)", what, got, want, cycle_count);
        error_count++;
    endtask

    always @(posedge clk)
    begin : check_results
        mm_pkg::result_word_t want;
        if (rst_n && strobe)
        begin
            if (want_wr == want_rd)
                report_mismatch("unexpected word", result.product_value, '0);
            else
            begin
                want = want_buf[7'(want_rd)];
                want_rd++;
                checked_count++;
                if (want.saturated)
                    saturated_count++;
                if (result.out_row !== want.out_row)
                    report_mismatch("out_row", 32'(result.out_row), 32'(want.out_row));
                if (result.out_col !== want.out_col)
                    report_mismatch("out_col", 32'(result.out_col), 32'(want.out_col));
                if (result.product_value !== want.product_value)
                    report_mismatch("product_value", result.product_value, want.product_value);
                if (result.saturated !== want.saturated)
                    report_mismatch("saturated", 32'(result.saturated), 32'(want.saturated));
                if (result.last !== want.last)
                    report_mismatch("last", 32'(result.last), 32'(want.last));
            end
        end
    end

    task automatic send_word(input mm_pkg::cmd_word_t w);
        if (gaps_on && $urandom_range(99) < 26)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 26);
        end
        start <= 1'b1;
        command <= w;
        do @(posedge clk); while (busy);
        apply_command(w);
    endtask

    task automatic settle();
        start <= 1'b0;
        while (want_wr != want_rd)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_dims(input logic [mm_pkg::DIM_W-1:0] ar,
                              input logic [mm_pkg::DIM_W-1:0] ac,
                              input logic [mm_pkg::DIM_W-1:0] br,
                              input logic [mm_pkg::DIM_W-1:0] bc);
        logic [mm_pkg::DIM_W-1:0] vals [4];
        logic [mm_pkg::CFG_IDX_W-1:0] regs [4];
        vals = '{ar, ac, br, bc};
        regs = '{mm_pkg::REG_A_ROWS, mm_pkg::REG_A_COLS, mm_pkg::REG_B_ROWS,
                 mm_pkg::REG_B_COLS};
        settle();
        cfg_valid <= 1'b1;
        for (int n = 0; n < 4; n++)
        begin
            cfg_index <= regs[n];
            cfg_data <= vals[n];
            do @(posedge clk); while (!cfg_ready);
            dim_reg[regs[n]] = vals[n];
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_state();
        send_word(start_word());
    endtask

    task automatic test_extremes();
        write_dims(4'd2, 4'd2, 4'd2, 4'd2);
        send_word(make_word(mm_pkg::ACTION_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
        send_word(make_word(mm_pkg::ACTION_LOAD_A, 3'd0, 3'd1, 32'h7FFF_FFFF));
        send_word(make_word(mm_pkg::ACTION_LOAD_A, 3'd1, 3'd0, 32'h8000_0000));
        send_word(make_word(mm_pkg::ACTION_LOAD_A, 3'd1, 3'd1, 32'h8000_0000));
        send_word(make_word(mm_pkg::ACTION_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
        send_word(make_word(mm_pkg::ACTION_LOAD_B, 3'd1, 3'd0, 32'h7FFF_FFFF));
        send_word(make_word(mm_pkg::ACTION_LOAD_B, 3'd0, 3'd1, 32'hFFFF_FFFF));
        send_word(make_word(mm_pkg::ACTION_LOAD_B, 3'd1, 3'd1, 32'h0000_0000));
        send_word(start_word());
        send_word(make_word(ACTION_UNUSED, 3'd7, 3'd7, $urandom));
        send_word(make_word(ACTION_UNUSED, 3'd0, 3'd0, $urandom));
        send_word(start_word());
    endtask

    task automatic test_dim_limits();
        write_dims(4'd0, 4'd8, 4'd8, 4'd8);
        send_word(start_word());
        write_dims(4'd1, 4'd0, 4'd8, 4'd1);
        send_word(start_word());
        write_dims(4'd15, 4'd15, 4'd15, 4'd15);
        send_word(make_word(mm_pkg::ACTION_LOAD_A, 3'd7, 3'd7, 32'h0003_8000));
        send_word(make_word(mm_pkg::ACTION_LOAD_B, 3'd7, 3'd7, 32'hFFFE_4000));
        send_word(start_word());
        write_dims(4'd2, 4'd3, 4'd1, 4'd0);
        send_word(start_word());
        write_dims(4'd1, 4'd1, 4'd1, 4'd1);
        send_word(start_word());
    endtask

    task automatic test_random_products();
        int sent;
        int phase;
        int unsigned r;
        sent = 0;
        phase = 0;
        while (sent < RANDOM_WORDS)
        begin
            if ($urandom_range(2) != 0)
                write_dims(pick_dim(), pick_dim(), pick_dim(), pick_dim());
            gaps_on = !(phase >= 3 && phase < 7);
            repeat ($urandom_range(4, 16))
            begin
                r = $urandom_range(99);
                if (r < 4)
                    send_word(make_word(ACTION_UNUSED, 3'($urandom), 3'($urandom), $urandom));
                else if (r < 8)
                begin
                    send_word(start_word());
                    sent++;
                end
                else if (r < 54)
                begin
                    send_word(make_word(mm_pkg::ACTION_LOAD_A,
                                        pick_index(dim_reg[mm_pkg::REG_A_ROWS]),
                                        pick_index(dim_reg[mm_pkg::REG_A_COLS]), pick_value()));
                    sent++;
                end
                else
                begin
                    send_word(make_word(mm_pkg::ACTION_LOAD_B,
                                        pick_index(dim_reg[mm_pkg::REG_B_ROWS]),
                                        pick_index(dim_reg[mm_pkg::REG_B_COLS]), pick_value()));
                    sent++;
                end
            end
            send_word(start_word());
            sent++;
            phase++;
        end
        gaps_on = 1'b1;
    endtask

    initial
    begin
        for (int r = 0; r < mm_pkg::MAX_DIM; r++)
        begin
            for (int c = 0; c < mm_pkg::MAX_DIM; c++)
            begin
                a_store[r][c] = '0;
                b_store[r][c] = '0;
            end
        end
        for (int n = 0; n < 4; n++)
            dim_reg[n] = mm_pkg::DIM_RESET;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_state();
        test_extremes();
        test_dim_limits();
        test_random_products();
        settle();

        $display("Covered %0d element loads, %0d multiplies, %0d ignored words",
                 load_count, multiply_count, ignored_count);
        $display("Checked %0d result elements, %0d of them saturated",
                 checked_count, saturated_count);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
